>>> rtl/adpcm_sample_encoder_top_defines.svh
// Assertion macros shared by the ADPCM encoder checkers.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef ADPCM_SAMPLE_ENCODER_TOP_DEFINES_SVH
`define ADPCM_SAMPLE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ENC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ENC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/adpcm_enc_pkg.sv
// Types, constants and tables of the ADPCM sample encoder.
// Depends on nothing; used by every module of the block.
package adpcm_enc_pkg;

  localparam logic [6:0] MAX_INDEX = 7'd88;
  localparam logic signed [17:0] PRED_HI = 18'sd32767;
  localparam logic signed [17:0] PRED_LO = -18'sd32768;

  // Configuration register indexes
  localparam logic CFG_INIT_PRED = 1'b0;
  localparam logic CFG_INIT_STEP = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               load_state;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         packed_byte;
    logic signed [15:0] predictor_out;
    logic [6:0]         step_index_out;
    logic               block_end;
  } out_item_t;

  // Status returned by the quantizer
  typedef struct packed {
    logic        done;
    logic [2:0]  code;
    logic [15:0] dq;
  } quant_res_t;

  localparam logic [14:0] STEP_TBL [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
    15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
    15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
    15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
    15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
    15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
    15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
    15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
    15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  function automatic logic [14:0] step_lookup(input logic [6:0] idx);
    step_lookup = (idx > MAX_INDEX) ? STEP_TBL[MAX_INDEX] : STEP_TBL[idx];
  endfunction

  // Step index adjustment per magnitude code
  function automatic logic signed [4:0] idx_delta(input logic [2:0] code);
    case (code)
      3'd4:    idx_delta = 5'sd2;
      3'd5:    idx_delta = 5'sd4;
      3'd6:    idx_delta = 5'sd6;
      3'd7:    idx_delta = 5'sd8;
      default: idx_delta = -5'sd1;
    endcase
  endfunction

endpackage

>>> rtl/adpcm_enc_quant.sv
// Bit-serial quantizer: code = min(7, 4*mag/step), dq = step*code/4 + step/8.
// Depends on adpcm_enc_pkg.
module adpcm_enc_quant (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [15:0]              mag,
  input  logic [14:0]              step,
  output adpcm_enc_pkg::quant_res_t res
);
  import adpcm_enc_pkg::*;

  localparam logic [2:0] QC_SAT  = 3'd0;
  localparam logic [2:0] QC_BIT2 = 3'd1;
  localparam logic [2:0] QC_BIT1 = 3'd2;
  localparam logic [2:0] QC_BIT0 = 3'd3;
  localparam logic [2:0] QC_FIN  = 3'd4;

  logic        busy_r, busy_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [14:0] stp_r, stp_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        sat_r, sat_nxt;
  logic [2:0]  code_r, code_nxt;
  logic [15:0] dq_r, dq_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;
  logic        qbit;

  // Divisor multiple tried in this cycle
  always_comb begin
    case (cnt_r)
      QC_BIT2: trial = {1'b0, stp_r, 2'b00};
      QC_BIT1: trial = {2'b00, stp_r, 1'b0};
      QC_BIT0: trial = {3'b000, stp_r};
      default: trial = 18'd0;
    endcase
  end

  // A saturated quotient forces every bit to one
  assign qbit = sat_r | (rem_r >= trial);

  // One quotient bit per cycle, product accumulated alongside
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    stp_nxt  = stp_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    code_nxt = code_r;
    dq_nxt   = dq_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = QC_SAT;
      rem_nxt  = {mag, 2'b00};
      stp_nxt  = step;
      acc_nxt  = 18'd0;
      sat_nxt  = 1'b0;
      code_nxt = 3'd0;
    end else if (busy_r) begin
      case (cnt_r)
        QC_SAT: begin
          sat_nxt = ({1'b0, rem_r} >= {1'b0, stp_r, 3'b000});
          cnt_nxt = QC_BIT2;
        end
        QC_BIT2, QC_BIT1, QC_BIT0: begin
          code_nxt = {code_r[1:0], qbit};
          if (qbit) begin
            acc_nxt = acc_r + trial;
          end
          if (qbit && !sat_r) begin
            rem_nxt = rem_r - trial;
          end
          cnt_nxt = cnt_r + 3'd1;
        end
        QC_FIN: begin
          dq_nxt   = acc_r[17:2] + {4'b0000, stp_r[14:3]};
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          cnt_nxt  = QC_SAT;
        end
        default: begin
          busy_nxt = 1'b0;
          cnt_nxt  = QC_SAT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= QC_SAT;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    stp_r  <= stp_nxt;
    acc_r  <= acc_nxt;
    sat_r  <= sat_nxt;
    code_r <= code_nxt;
    dq_r   <= dq_nxt;
  end

  assign res.done = done_r;
  assign res.code = code_r;
  assign res.dq   = dq_r;

endmodule

>>> rtl/adpcm_sample_encoder_top.sv
// Top level of the 4-bit ADPCM sample encoder.
// Depends on adpcm_enc_pkg and adpcm_enc_quant.
//
// One item is one signed 16-bit sample; every second code (or a lone code
// marked last) yields one packed byte with the updated predictor and step
// index. From acceptance until in_ready returns, an item passes through
// forming the difference and looking up the step, the bit-serial quantizer
// (saturation check, three quotient bits, step rescale), picking up its
// result and updating predictor and index. A finished byte sits in an
// output register, so the next item is taken while it waits; the update
// cycle holds only when a new byte is due while the old one is still unread.
module adpcm_sample_encoder_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  adpcm_enc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output adpcm_enc_pkg::out_item_t out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [15:0]              cfg_wdata
);
  import adpcm_enc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PREP  = 2'd1;
  localparam logic [1:0] S_QUANT = 2'd2;
  localparam logic [1:0] S_UPD   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic signed [15:0] sample_r, sample_nxt;
  logic               last_r, last_nxt;
  logic signed [15:0] pred_r, pred_nxt;
  logic [6:0]         idx_r, idx_nxt;
  logic [3:0]         held_r, held_nxt;
  logic               phase_r, phase_nxt;
  logic               sign_r, sign_nxt;
  logic signed [15:0] cfg_pred_r;
  logic [6:0]         cfg_idx_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [14:0]        step_w;
  logic signed [16:0] diff_pos, diff_neg;
  logic [15:0]        mag_w;
  quant_res_t         qres;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_sat;
  logic signed [4:0]  idx_d;
  logic signed [8:0]  idx_sum;
  logic [6:0]         idx_new;
  logic [3:0]         nib;
  logic               emit;
  logic               out_free;

  // Difference and magnitude, both signs formed in parallel
  assign step_w   = step_lookup(idx_r);
  assign diff_pos = {sample_r[15], sample_r} - {pred_r[15], pred_r};
  assign diff_neg = {pred_r[15], pred_r} - {sample_r[15], sample_r};
  assign mag_w    = diff_pos[16] ? diff_neg[15:0] : diff_pos[15:0];

  adpcm_enc_quant u_quant (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_PREP),
    .mag   (mag_w),
    .step  (step_w),
    .res   (qres)
  );

  // Predictor update with 16-bit saturation
  always_comb begin
    pred_sum = sign_r ? ({{2{pred_r[15]}}, pred_r} - $signed({2'b00, qres.dq}))
                      : ({{2{pred_r[15]}}, pred_r} + $signed({2'b00, qres.dq}));
    if (pred_sum > PRED_HI) begin
      pred_sat = PRED_HI[15:0];
    end else if (pred_sum < PRED_LO) begin
      pred_sat = PRED_LO[15:0];
    end else begin
      pred_sat = pred_sum[15:0];
    end
  end

  // Step index update clamped to the table
  assign idx_d = idx_delta(qres.code);

  always_comb begin
    idx_sum = $signed({2'b00, idx_r}) + $signed({{4{idx_d[4]}}, idx_d});
    if (idx_sum < 9'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > $signed({2'b00, MAX_INDEX})) begin
      idx_new = MAX_INDEX;
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  assign nib      = {sign_r, qres.code};
  assign emit     = phase_r | last_r;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    pred_nxt      = pred_r;
    idx_nxt       = idx_r;
    held_nxt      = held_r;
    phase_nxt     = phase_r;
    sign_nxt      = sign_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_data.sample;
          last_nxt   = in_data.last_sample;
          if (in_data.load_state) begin
            pred_nxt  = cfg_pred_r;
            idx_nxt   = (cfg_idx_r > MAX_INDEX) ? MAX_INDEX : cfg_idx_r;
            phase_nxt = 1'b0;
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        sign_nxt  = diff_pos[16];
        state_nxt = S_QUANT;
      end
      S_QUANT: begin
        if (qres.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (!emit || out_free) begin
          pred_nxt  = pred_sat;
          idx_nxt   = idx_new;
          phase_nxt = !emit;
          if (!emit) begin
            held_nxt = nib;
          end else begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.packed_byte    = phase_r ? {held_r, nib} : {nib, 4'b0000};
            out_data_nxt.predictor_out  = pred_sat;
            out_data_nxt.step_index_out = idx_new;
            out_data_nxt.block_end      = last_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pred_r      <= 16'sd0;
      idx_r       <= 7'd0;
      held_r      <= 4'd0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pred_r      <= pred_nxt;
      idx_r       <= idx_nxt;
      held_r      <= held_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    sign_r     <= sign_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pred_r <= 16'sd0;
      cfg_idx_r  <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_INIT_PRED: cfg_pred_r <= cfg_wdata;
        CFG_INIT_STEP: cfg_idx_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/adpcm_enc_chk.sv
// Port-level checker for the ADPCM encoder, bound to the top level.
// Depends on adpcm_enc_pkg and adpcm_sample_encoder_top_defines.svh.
`include "adpcm_sample_encoder_top_defines.svh"

module adpcm_enc_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input adpcm_enc_pkg::out_item_t out_data
);
  import adpcm_enc_pkg::*;

  // A stalled byte stays offered
  `ENC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output item dropped")

  // A stalled byte keeps its payload
  `ENC_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "output item changed")

  // One item at a time: busy right after an accept
  `ENC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while busy")

  // Reported step index stays inside the table
  `ENC_ASSERT_IMP(a_idx_range, out_valid, out_data.step_index_out <= MAX_INDEX, "step index beyond table")

endmodule

bind adpcm_sample_encoder_top adpcm_enc_chk u_adpcm_enc_chk (.*);
